>>> rtl/core/afor_pkg.sv
// ----------------------------------------------------------------------------
// afor_pkg
// Shared types and constants for the first-order ambisonic rotation core.
// ----------------------------------------------------------------------------
package afor_pkg;

  localparam int COEF_W    = 18;
  localparam int CFG_IDX_W = 3;

  // Configuration register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIN_ALPHA = 3'd0,
    REG_COS_ALPHA = 3'd1,
    REG_SIN_BETA  = 3'd2,
    REG_COS_BETA  = 3'd3,
    REG_SIN_GAMMA = 3'd4,
    REG_COS_GAMMA = 3'd5
  } reg_idx_t;

  // Reset coefficients, Q2.16
  localparam logic signed [COEF_W-1:0] RST_SIN_ALPHA = -18'sd65536;
  localparam logic signed [COEF_W-1:0] RST_COS_ALPHA = 18'sd0;
  localparam logic signed [COEF_W-1:0] RST_SIN_BETA  = 18'sd56791;
  localparam logic signed [COEF_W-1:0] RST_COS_BETA  = -18'sd32707;
  localparam logic signed [COEF_W-1:0] RST_SIN_GAMMA = 18'sd65536;
  localparam logic signed [COEF_W-1:0] RST_COS_GAMMA = 18'sd0;

  // Sine and cosine of one planar rotation
  typedef struct packed {
    logic signed [COEF_W-1:0] sin_c;
    logic signed [COEF_W-1:0] cos_c;
  } coef_pair_t;

endpackage

>>> rtl/core/afor_coef_regs.sv
// ----------------------------------------------------------------------------
// afor_coef_regs
// Coefficient register file: six Q2.16 sine/cosine registers, write only.
// ----------------------------------------------------------------------------
module afor_coef_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wen,
  input  logic [afor_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [afor_pkg::COEF_W-1:0]      cfg_data,
  output afor_pkg::coef_pair_t             alpha,
  output afor_pkg::coef_pair_t             beta,
  output afor_pkg::coef_pair_t             gamma
);

  logic signed [afor_pkg::COEF_W-1:0] sin_alpha;
  logic signed [afor_pkg::COEF_W-1:0] cos_alpha;
  logic signed [afor_pkg::COEF_W-1:0] sin_beta;
  logic signed [afor_pkg::COEF_W-1:0] cos_beta;
  logic signed [afor_pkg::COEF_W-1:0] sin_gamma;
  logic signed [afor_pkg::COEF_W-1:0] cos_gamma;

  always_ff @(posedge clk) begin
    if (rst) begin
      sin_alpha <= afor_pkg::RST_SIN_ALPHA;
      cos_alpha <= afor_pkg::RST_COS_ALPHA;
      sin_beta  <= afor_pkg::RST_SIN_BETA;
      cos_beta  <= afor_pkg::RST_COS_BETA;
      sin_gamma <= afor_pkg::RST_SIN_GAMMA;
      cos_gamma <= afor_pkg::RST_COS_GAMMA;
    end else if (cfg_wen) begin
      case (afor_pkg::reg_idx_t'(cfg_index))
        afor_pkg::REG_SIN_ALPHA: sin_alpha <= cfg_data;
        afor_pkg::REG_COS_ALPHA: cos_alpha <= cfg_data;
        afor_pkg::REG_SIN_BETA:  sin_beta  <= cfg_data;
        afor_pkg::REG_COS_BETA:  cos_beta  <= cfg_data;
        afor_pkg::REG_SIN_GAMMA: sin_gamma <= cfg_data;
        afor_pkg::REG_COS_GAMMA: cos_gamma <= cfg_data;
        default: ; // unmapped index: drop the write
      endcase
    end
  end

  assign alpha.sin_c = sin_alpha;
  assign alpha.cos_c = cos_alpha;
  assign beta.sin_c  = sin_beta;
  assign beta.cos_c  = cos_beta;
  assign gamma.sin_c = sin_gamma;
  assign gamma.cos_c = cos_gamma;

endmodule

>>> rtl/core/afor_rot_stage.sv
// ----------------------------------------------------------------------------
// afor_rot_stage
// One planar rotation, two register stages:
//   u = sat(x*c - y*s), v = sat(y*c + x*s), rounded by half and shifted by 16.
// A side payload (untouched channel and frame flag) travels alongside.
// ----------------------------------------------------------------------------
module afor_rot_stage #(
  parameter int SW      = 24,
  parameter int CARRY_W = 25
) (
  input  logic                      clk,
  input  logic                      rst,
  input  afor_pkg::coef_pair_t      coef,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [SW-1:0]      in_x,
  input  logic signed [SW-1:0]      in_y,
  input  logic [CARRY_W-1:0]        in_carry,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [SW-1:0]      out_u,
  output logic signed [SW-1:0]      out_v,
  output logic [CARRY_W-1:0]        out_carry
);

  localparam int PROD_W = SW + afor_pkg::COEF_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int Q_W    = SUM_W - 16;
  localparam logic signed [SUM_W-1:0] RND = SUM_W'(32768);

  // Stage 1: products
  logic                     v1;
  logic signed [PROD_W-1:0] p_xc;
  logic signed [PROD_W-1:0] p_ys;
  logic signed [PROD_W-1:0] p_yc;
  logic signed [PROD_W-1:0] p_xs;
  logic [CARRY_W-1:0]       carry1;
  logic                     rdy1;

  // Stage 2: rounded, saturated results
  logic                     v2;
  logic signed [SW-1:0]     u2;
  logic signed [SW-1:0]     v2_val;
  logic [CARRY_W-1:0]       carry2;
  logic                     rdy2;

  logic signed [SUM_W-1:0]  sum_u;
  logic signed [SUM_W-1:0]  sum_v;
  logic signed [SW-1:0]     u_next;
  logic signed [SW-1:0]     v_next;

  function automatic logic signed [SW-1:0] round_sat(input logic signed [SUM_W-1:0] s);
    logic [Q_W-1:0] q;
    logic [4:0]     hi_bits;
    q       = s[SUM_W-1:16];
    hi_bits = q[Q_W-1:SW-1];
    if ((&hi_bits) || !(|hi_bits)) begin
      return q[SW-1:0];
    end else if (q[Q_W-1]) begin
      return {1'b1, {(SW-1){1'b0}}};
    end else begin
      return {1'b0, {(SW-1){1'b1}}};
    end
  endfunction

  assign rdy2     = !v2 || out_ready;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= in_valid;
    end
    if (rdy1 && in_valid) begin
      p_xc   <= in_x * coef.cos_c;
      p_ys   <= in_y * coef.sin_c;
      p_yc   <= in_y * coef.cos_c;
      p_xs   <= in_x * coef.sin_c;
      carry1 <= in_carry;
    end
  end

  always_comb begin
    sum_u  = $signed({{2{p_xc[PROD_W-1]}}, p_xc}) - $signed({{2{p_ys[PROD_W-1]}}, p_ys}) + RND;
    sum_v  = $signed({{2{p_yc[PROD_W-1]}}, p_yc}) + $signed({{2{p_xs[PROD_W-1]}}, p_xs}) + RND;
    u_next = round_sat(sum_u);
    v_next = round_sat(sum_v);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
    if (rdy2 && v1) begin
      u2     <= u_next;
      v2_val <= v_next;
      carry2 <= carry1;
    end
  end

  assign out_valid = v2;
  assign out_u     = u2;
  assign out_v     = v2_val;
  assign out_carry = carry2;

`ifndef ASSERT_OFF
  // A transfer in must land in stage 1
  a_load_s1 : assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> v1)
    else $error("rot stage: accepted transfer missing from stage 1");

  // Stage 1 holds its products while stage 2 cannot take them
  a_hold_s1 : assert property (@(posedge clk) disable iff (rst)
    v1 && !rdy2 |=> v1 && $stable(p_xc) && $stable(p_yc) && $stable(carry1))
    else $error("rot stage: stage 1 lost data under stall");

  // A full stage 2 with a stalled output keeps the stage 1 item in flight
  a_no_drop : assert property (@(posedge clk) disable iff (rst)
    v1 && v2 && !out_ready |=> v1 && v2)
    else $error("rot stage: item dropped under back-pressure");

  a_reset_empty : assert property (@(posedge clk)
    rst |=> !v1 && !v2)
    else $error("rot stage: pipeline not empty after reset");
`endif

endmodule

>>> rtl/core/ambisonic_first_order_rotation_core.sv
// ----------------------------------------------------------------------------
// ambisonic_first_order_rotation_core
// Rotates one three-channel first-order ambisonic sample through alpha, beta
// and gamma planar rotations with Q2.16 sine/cosine coefficients.
//
//   channel   direction  handshake          payload
//   s_*       in         tvalid / tready    tdata: chan0, chan1, chan2; tlast
//   m_*       out        tvalid / tready    tdata: chan0, chan1, chan2; tlast
//   cfg_*     in         cfg_wen            cfg_index, cfg_data
//
// One transfer per cycle sustained while m_tready stays high; six register
// stages in all (two per rotation: multiply, then round and saturate).
// Reset clears every valid bit and loads the default coefficients.
// Each stage advances when empty or when the stage after it advances, so a
// stall at m_tready fills bubbles first and reaches s_tready only when all
// six stages are full.
// ----------------------------------------------------------------------------
module ambisonic_first_order_rotation_core #(
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wen,
  input  logic [afor_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [afor_pkg::COEF_W-1:0]         cfg_data,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // chan_zero_in, chan_one_in, chan_two_in (low bits up), zero padded
  input  logic [((3*SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,
  input  logic                                s_tlast,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // chan_zero_out, chan_one_out, chan_two_out (low bits up), zero padded
  output logic [((3*SAMPLE_WIDTH+7)/8)*8-1:0] m_tdata,
  output logic                                m_tlast
);

  localparam int SW      = SAMPLE_WIDTH;
  localparam int DATA_W  = ((3*SW+7)/8)*8;
  localparam int CARRY_W = SW + 1;

  afor_pkg::coef_pair_t alpha;
  afor_pkg::coef_pair_t beta;
  afor_pkg::coef_pair_t gamma;

  logic signed [SW-1:0] chan_zero_in;
  logic signed [SW-1:0] chan_one_in;
  logic signed [SW-1:0] chan_two_in;

  logic                 a_valid;
  logic                 a_ready;
  logic signed [SW-1:0] a0;
  logic signed [SW-1:0] a2;
  logic [CARRY_W-1:0]   a_carry;

  logic                 b_valid;
  logic                 b_ready;
  logic signed [SW-1:0] b1;
  logic signed [SW-1:0] b2;
  logic [CARRY_W-1:0]   b_carry;

  logic signed [SW-1:0] chan_zero_out;
  logic signed [SW-1:0] chan_two_out;
  logic [CARRY_W-1:0]   g_carry;

  assign chan_zero_in = s_tdata[SW-1:0];
  assign chan_one_in  = s_tdata[2*SW-1:SW];
  assign chan_two_in  = s_tdata[3*SW-1:2*SW];

  afor_coef_regs u_coef (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .alpha     (alpha),
    .beta      (beta),
    .gamma     (gamma)
  );

  // alpha mixes channels 0 and 2; channel 1 rides along
  afor_rot_stage #(.SW(SW), .CARRY_W(CARRY_W)) u_alpha (
    .clk       (clk),
    .rst       (rst),
    .coef      (alpha),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_x      (chan_zero_in),
    .in_y      (chan_two_in),
    .in_carry  ({s_tlast, chan_one_in}),
    .out_valid (a_valid),
    .out_ready (a_ready),
    .out_u     (a0),
    .out_v     (a2),
    .out_carry (a_carry)
  );

  // beta: x = a2, y = a1 gives u = b2, v = b1; a0 rides along
  afor_rot_stage #(.SW(SW), .CARRY_W(CARRY_W)) u_beta (
    .clk       (clk),
    .rst       (rst),
    .coef      (beta),
    .in_valid  (a_valid),
    .in_ready  (a_ready),
    .in_x      (a2),
    .in_y      (a_carry[SW-1:0]),
    .in_carry  ({a_carry[SW], a0}),
    .out_valid (b_valid),
    .out_ready (b_ready),
    .out_u     (b2),
    .out_v     (b1),
    .out_carry (b_carry)
  );

  // gamma mixes channels 0 and 2 again; b1 rides along
  afor_rot_stage #(.SW(SW), .CARRY_W(CARRY_W)) u_gamma (
    .clk       (clk),
    .rst       (rst),
    .coef      (gamma),
    .in_valid  (b_valid),
    .in_ready  (b_ready),
    .in_x      (b_carry[SW-1:0]),
    .in_y      (b2),
    .in_carry  ({b_carry[SW], b1}),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_u     (chan_zero_out),
    .out_v     (chan_two_out),
    .out_carry (g_carry)
  );

  assign m_tdata = DATA_W'({chan_two_out, g_carry[SW-1:0], chan_zero_out});
  assign m_tlast = g_carry[SW];

endmodule
